// ===== design/aalu_pkg.sv =====
package aalu_pkg;

   localparam int QDepth = 2;
   localparam int QPtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
   localparam int QCntW = $clog2(QDepth + 1);

   localparam int FlagS = 7;
   localparam int FlagZ = 6;
   localparam int FlagAc = 4;
   localparam int FlagP = 2;
   localparam int FlagCy = 0;

   typedef enum logic [4:0] {
      OP_LOAD,
      OP_NOP,
      OP_BAD,
      OP_ADD,
      OP_SUB,
      OP_CMP,
      OP_AND,
      OP_XOR,
      OP_OR,
      OP_INR,
      OP_DCR,
      OP_RLC,
      OP_RRC,
      OP_RAL,
      OP_RAR,
      OP_CMA,
      OP_STC,
      OP_CMC
   } op_class_type;

   typedef struct packed {
      op_class_type cls;
      logic [7:0]   operand;
   } item_type;

   function automatic logic [7:0] make_flags(input logic [7:0] v, input logic ac,
                                             input logic cy);
      logic [7:0] f;
      f = 8'h00;
      f[FlagS] = v[7];
      f[FlagZ] = (v == 8'h00);
      f[FlagAc] = ac;
      f[FlagP] = ~^v;
      f[FlagCy] = cy;
      return f;
   endfunction

endpackage

// ===== design/accumulator_alu_8bit_flags.sv =====
// 8-bit accumulator alu with an 8085-style flag byte (S Z AC P CY)
// request channel: req_valid/req_ready with req_type, req_opcode, req_operand;
//    req_type 0 loads the accumulator from req_operand, 1 executes req_opcode
// response channel: rsp_valid/rsp_ready with rsp_acc_out, rsp_flags_out and
//    rsp_bad_opcode; exactly one response per request transfer, in order
// the front decodes each request into an operation class and pushes it into
// a two-entry queue; the back pops one entry per cycle unless the response
// is stalled, updates the accumulator and flags and holds the new state as
// the response; each request passes through its queue entry and then the
// registered accumulator state before rsp_valid rises
// throughput: one request per cycle while responses are not stalled
// a stalled response holds its values; requests keep being taken until the
// queue fills, then req_ready drops
// reset clears the accumulator, the flags and the queue, no response pending
module accumulator_alu_8bit_flags (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_type,
   input  logic [7:0] req_opcode,
   input  logic [7:0] req_operand,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_acc_out,
   output logic [7:0] rsp_flags_out,
   output logic       rsp_bad_opcode
);
   import aalu_pkg::*;

   item_type dec_item;
   item_type q_item;
   logic     q_valid, q_ready;

   aalu_decode u_decode (
      .req_type    (req_type),
      .req_opcode  (req_opcode),
      .req_operand (req_operand),
      .item        (dec_item)
   );

   aalu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_item  (dec_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_item   (q_item)
   );

   aalu_exec u_exec (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_ready        (q_ready),
      .q_item         (q_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_acc_out    (rsp_acc_out),
      .rsp_flags_out  (rsp_flags_out),
      .rsp_bad_opcode (rsp_bad_opcode)
   );

endmodule

// ===== design/aalu_decode.sv =====
module aalu_decode (
   input  logic              req_type,
   input  logic [7:0]        req_opcode,
   input  logic [7:0]        req_operand,
   output aalu_pkg::item_type item
);
   import aalu_pkg::*;

   localparam logic [7:0] OPC_LXI_D  = 8'h11;
   localparam logic [7:0] OPC_LXI_H  = 8'h21;
   localparam logic [7:0] OPC_LXI_SP = 8'h31;
   localparam logic [7:0] OPC_CALL   = 8'hcd;
   localparam logic [7:0] OPC_ACI    = 8'hce;
   localparam logic [7:0] OPC_CC     = 8'hdc;
   localparam logic [7:0] OPC_CM     = 8'hfc;
   localparam logic [7:0] OPC_LOW_LO = 8'h00;
   localparam logic [7:0] OPC_LOW_HI = 8'h06;
   localparam logic [7:0] OPC_MOV_LO = 8'h40;
   localparam logic [7:0] OPC_MOV_HI = 8'h6f;
   localparam logic [7:0] OPC_MOVA_LO = 8'h78;
   localparam logic [7:0] OPC_MOVA_HI = 8'h7f;
   localparam logic [7:0] GRP_ADC    = 8'b10001???;
   localparam logic [7:0] GRP_ADD    = 8'b10000???;
   localparam logic [7:0] GRP_SUB    = 8'b10010???;
   localparam logic [7:0] GRP_CMP    = 8'b10111???;
   localparam logic [7:0] GRP_ANA    = 8'b10100???;
   localparam logic [7:0] GRP_XRA    = 8'b10101???;
   localparam logic [7:0] GRP_ORA    = 8'b10110???;
   localparam logic [7:0] OPC_ADI    = 8'hc6;
   localparam logic [7:0] OPC_SUI    = 8'hd6;
   localparam logic [7:0] OPC_CPI    = 8'hfe;
   localparam logic [7:0] OPC_ANI    = 8'he6;
   localparam logic [7:0] OPC_XRI    = 8'hee;
   localparam logic [7:0] OPC_ORI    = 8'hf6;
   localparam logic [7:0] OPC_RLC    = 8'h07;
   localparam logic [7:0] OPC_RRC    = 8'h0f;
   localparam logic [7:0] OPC_RAL    = 8'h17;
   localparam logic [7:0] OPC_RAR    = 8'h1f;
   localparam logic [7:0] OPC_CMA    = 8'h2f;
   localparam logic [7:0] OPC_STC    = 8'h37;
   localparam logic [7:0] OPC_CMC    = 8'h3f;
   localparam logic [7:0] OPC_INR_A  = 8'h3c;
   localparam logic [7:0] OPC_DCR_A  = 8'h3d;

   op_class_type cls;

   always_comb begin
      if (!req_type) begin
         cls = OP_LOAD;
      end else begin
         case (req_opcode) inside
            [OPC_LOW_LO:OPC_LOW_HI], OPC_LXI_D, OPC_LXI_H, OPC_LXI_SP,
            [OPC_MOV_LO:OPC_MOV_HI], [OPC_MOVA_LO:OPC_MOVA_HI], GRP_ADC,
            OPC_CALL, OPC_ACI, OPC_CC, OPC_CM: cls = OP_NOP;
            GRP_ADD, OPC_ADI: cls = OP_ADD;
            GRP_SUB, OPC_SUI: cls = OP_SUB;
            GRP_CMP, OPC_CPI: cls = OP_CMP;
            GRP_ANA, OPC_ANI: cls = OP_AND;
            GRP_XRA, OPC_XRI: cls = OP_XOR;
            GRP_ORA, OPC_ORI: cls = OP_OR;
            OPC_RLC:   cls = OP_RLC;
            OPC_RRC:   cls = OP_RRC;
            OPC_RAL:   cls = OP_RAL;
            OPC_RAR:   cls = OP_RAR;
            OPC_CMA:   cls = OP_CMA;
            OPC_STC:   cls = OP_STC;
            OPC_CMC:   cls = OP_CMC;
            OPC_INR_A: cls = OP_INR;
            OPC_DCR_A: cls = OP_DCR;
            default:   cls = OP_BAD;
         endcase
      end
      item.cls = cls;
      item.operand = req_operand;
   end

endmodule

// ===== design/aalu_queue.sv =====
module aalu_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  aalu_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output aalu_pkg::item_type pop_item
);
   import aalu_pkg::*;

   item_type             mem_ff [QDepth];
   logic [QPtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0]     count_ff, count_in;
   logic                 push, pop;

   assign push_ready = (count_ff != QCntW'(QDepth));
   assign pop_valid = (count_ff != '0);
   assign pop_item = mem_ff[rd_ptr_ff];
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCntW'(QDepth))
      else $error("queue count above depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == QCntW'(QDepth)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

// ===== design/aalu_exec.sv =====
module aalu_exec (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_ready,
   input  aalu_pkg::item_type q_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_acc_out,
   output logic [7:0]         rsp_flags_out,
   output logic               rsp_bad_opcode
);
   import aalu_pkg::*;

   logic [7:0] acc_ff, acc_in;
   logic [7:0] flags_ff, flags_in;
   logic       valid_ff, valid_in;
   logic       bad_ff, bad_in;
   logic       fire;
   logic [7:0] a, b, nb, diff;
   logic [8:0] sum;
   logic [4:0] lo_add, lo_sub;
   logic       cy;

   assign q_ready = !valid_ff || rsp_ready;
   assign fire = q_valid && q_ready;

   always_comb begin
      a = acc_ff;
      b = q_item.operand;
      cy = flags_ff[FlagCy];
      sum = {1'b0, a} + {1'b0, b};
      lo_add = {1'b0, a[3:0]} + {1'b0, b[3:0]};
      nb = 8'h00 - b;
      diff = a + nb;
      lo_sub = {1'b0, a[3:0]} + {1'b0, nb[3:0]};

      acc_in = acc_ff;
      flags_in = flags_ff;
      bad_in = bad_ff;
      valid_in = valid_ff && !rsp_ready;
      if (fire) begin
         valid_in = 1'b1;
         bad_in = 1'b0;
         case (q_item.cls)
            OP_LOAD: acc_in = b;
            OP_NOP:  ;
            OP_BAD:  bad_in = 1'b1;
            OP_ADD: begin
               acc_in = sum[7:0];
               flags_in = make_flags(sum[7:0], lo_add[4], sum[8]);
            end
            OP_SUB: begin
               acc_in = diff;
               flags_in = make_flags(diff, lo_sub[4], a < b);
            end
            OP_CMP: flags_in = make_flags(diff, lo_sub[4], a < b);
            OP_AND: begin
               acc_in = a & b;
               flags_in = make_flags(a & b, 1'b1, 1'b0);
            end
            OP_XOR: begin
               acc_in = a ^ b;
               flags_in = make_flags(a ^ b, 1'b0, 1'b0);
            end
            OP_OR: begin
               acc_in = a | b;
               flags_in = make_flags(a | b, 1'b0, 1'b0);
            end
            OP_INR: begin
               acc_in = a + 8'h01;
               flags_in = make_flags(a + 8'h01, a[3:0] == 4'hf, cy);
            end
            OP_DCR: begin
               acc_in = a - 8'h01;
               flags_in = make_flags(a - 8'h01, a[3:0] == 4'h0, cy);
            end
            OP_RLC: begin
               acc_in = {a[6:0], a[7]};
               flags_in[FlagCy] = a[7];
            end
            OP_RRC: begin
               acc_in = {a[0], a[7:1]};
               flags_in[FlagCy] = a[0];
            end
            OP_RAL: begin
               acc_in = {a[6:0], cy};
               flags_in[FlagCy] = a[7];
            end
            OP_RAR: begin
               acc_in = {cy, a[7:1]};
               flags_in[FlagCy] = a[0];
            end
            OP_CMA:  acc_in = ~a;
            OP_STC:  flags_in[FlagCy] = 1'b1;
            OP_CMC:  flags_in[FlagCy] = ~cy;
            default: bad_in = 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         flags_ff <= '0;
         valid_ff <= 1'b0;
         bad_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         flags_ff <= flags_in;
         valid_ff <= valid_in;
         bad_ff <= bad_in;
      end
   end

   // state after the step is the result, held until the next transfer
   assign rsp_valid = valid_ff;
   assign rsp_acc_out = acc_ff;
   assign rsp_flags_out = flags_ff;
   assign rsp_bad_opcode = bad_ff;

   a_unused_flags: assert property (@(posedge clock) disable iff (reset)
      flags_ff[5] == 1'b0 && flags_ff[3] == 1'b0 && flags_ff[1] == 1'b0)
      else $error("reserved flag bit set");

   a_bad_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (fire && q_item.cls == OP_BAD) |=>
      (rsp_bad_opcode && acc_ff == $past(acc_ff) && flags_ff == $past(flags_ff)))
      else $error("bad opcode changed state");

   a_load_keeps_flags: assert property (@(posedge clock) disable iff (reset)
      (fire && q_item.cls == OP_LOAD) |=>
      (flags_ff == $past(flags_ff) && acc_ff == $past(q_item.operand) && !rsp_bad_opcode))
      else $error("load result wrong");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (acc_ff == $past(acc_ff) && rsp_valid))
      else $error("result changed while stalled");

endmodule
